### rtl/ssm_pkg.sv
// shared types, constants and register codes for the scan sector minimum block
package ssm_pkg;

    // field widths
    localparam int RANGE_W   = 16;
    localparam int ANGLE_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    typedef logic [RANGE_W-1:0] t_range;
    typedef logic [ANGLE_W-1:0] t_angle;

    // empty sector / saturated range value
    localparam t_range RANGE_MAX = {RANGE_W{1'b1}};

    // sector boundaries as binary angles
    localparam t_angle ANG_QUARTER = t_angle'(1 << (ANGLE_W - 2));
    localparam t_angle ANG_THREE_Q = t_angle'(3 << (ANGLE_W - 2));
    localparam t_angle ANG_DEG30   = t_angle'((1 << ANGLE_W) / 12);
    localparam t_angle ANG_DEG330  = t_angle'((1 << ANGLE_W) - ((1 << ANGLE_W) / 12));

    // register reset values
    localparam t_range WIDE_LIMIT_RST   = t_range'(1200);
    localparam t_range NARROW_LIMIT_RST = t_range'(200);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_ANGLE  = 3'd0,
        CFG_ANGLE_STEP   = 3'd1,
        CFG_CONE_MODE    = 3'd2,
        CFG_WIDE_LIMIT   = 3'd3,
        CFG_NARROW_LIMIT = 3'd4
    } t_cfg_idx;

    // obstacle cone selection
    typedef enum logic [1:0] {
        MODE_WIDE   = 2'd0,
        MODE_NARROW = 2'd1,
        MODE_NONE   = 2'd2,
        MODE_OFF    = 2'd3
    } t_cone_mode;

    typedef struct packed {
        t_angle            start_angle;
        logic signed [15:0] angle_step;
        t_cone_mode        cone_mode;
        t_range            wide_limit_mm;
        t_range            narrow_limit_mm;
    } t_cfg;

    typedef struct packed {
        t_range range_mm;
        logic   sample_valid;
        logic   last_sample;
    } t_in_item;

    typedef struct packed {
        t_range nearest_mm;
        t_angle nearest_bearing;
        t_range left_clear_mm;
        t_range right_clear_mm;
        t_range front_clear_mm;
        logic   obstacle_seen;
    } t_out_item;

endpackage

### rtl/ssm_cfg_regs.sv
// configuration register file for the scan sector minimum block
module ssm_cfg_regs
    import ssm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic [CFG_IDX_W-1:0] i_index,
    input  logic [CFG_DAT_W-1:0] i_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            unique case (i_index)
                CFG_START_ANGLE:  n_cfg.start_angle     = t_angle'(i_data);
                CFG_ANGLE_STEP:   n_cfg.angle_step      = $signed(i_data[15:0]);
                CFG_CONE_MODE:    n_cfg.cone_mode       = t_cone_mode'(i_data[1:0]);
                CFG_WIDE_LIMIT:   n_cfg.wide_limit_mm   = t_range'(i_data);
                CFG_NARROW_LIMIT: n_cfg.narrow_limit_mm = t_range'(i_data);
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_angle     <= '0;
            r_cfg.angle_step      <= '0;
            r_cfg.cone_mode       <= MODE_WIDE;
            r_cfg.wide_limit_mm   <= WIDE_LIMIT_RST;
            r_cfg.narrow_limit_mm <= NARROW_LIMIT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/ssm_accum.sv
// per-scan bearing and minimum accumulators with the sample update logic
module ssm_accum
    import ssm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_upd,
    input  t_in_item  i_item,
    output t_out_item o_res,
    output logic      o_emit
);

    logic   r_scan_start;
    t_angle r_bearing_acc;
    t_range r_best_range;
    t_angle r_best_bearing;
    t_range r_left_min;
    t_range r_right_min;
    t_range r_front_min;
    logic   r_hit_flag;

    logic   n_scan_start;
    t_angle n_bearing_acc;
    t_range n_best_range;
    t_angle n_best_bearing;
    t_range n_left_min;
    t_range n_right_min;
    t_range n_front_min;
    logic   n_hit_flag;

    t_angle bearing;
    logic   in_front;
    logic   in_wide;
    logic   active;

    // bearing of this sample and sector membership
    assign bearing  = r_scan_start ? i_cfg.start_angle : r_bearing_acc;
    assign in_front = (bearing <= ANG_DEG30) || (bearing >= ANG_DEG330);
    assign in_wide  = (bearing <= ANG_QUARTER) || (bearing >= ANG_THREE_Q);
    assign active   = (i_cfg.cone_mode != MODE_OFF);
    assign o_emit   = active && i_item.last_sample;

    // running minima including the current sample
    always_comb begin
        n_best_range   = r_best_range;
        n_best_bearing = r_best_bearing;
        n_left_min     = r_left_min;
        n_right_min    = r_right_min;
        n_front_min    = r_front_min;
        n_hit_flag     = r_hit_flag;
        if (i_item.sample_valid) begin
            if (i_item.range_mm < r_best_range) begin
                n_best_range   = i_item.range_mm;
                n_best_bearing = bearing;
            end
            if ((bearing != '0) && (bearing <= ANG_QUARTER)) begin
                if (i_item.range_mm < r_left_min) begin
                    n_left_min = i_item.range_mm;
                end
            end else if (bearing >= ANG_THREE_Q) begin
                if (i_item.range_mm < r_right_min) begin
                    n_right_min = i_item.range_mm;
                end
            end
            if (in_front && (i_item.range_mm < r_front_min)) begin
                n_front_min = i_item.range_mm;
            end
            if ((i_cfg.cone_mode == MODE_WIDE) && in_wide
                    && (i_item.range_mm < i_cfg.wide_limit_mm)) begin
                n_hit_flag = 1'b1;
            end else if ((i_cfg.cone_mode == MODE_NARROW) && in_front
                    && (i_item.range_mm < i_cfg.narrow_limit_mm)) begin
                n_hit_flag = 1'b1;
            end
        end
        n_bearing_acc = bearing + t_angle'(i_cfg.angle_step);
        n_scan_start  = 1'b0;
    end

    // result of a closing sample
    always_comb begin
        o_res.nearest_mm      = n_best_range;
        o_res.nearest_bearing = n_best_bearing;
        o_res.left_clear_mm   = n_left_min;
        o_res.right_clear_mm  = n_right_min;
        o_res.front_clear_mm  = n_front_min;
        o_res.obstacle_seen   = n_hit_flag;
    end

    // accumulator update, cleared after the last sample of a scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_upd && o_emit)) begin
            r_scan_start   <= 1'b1;
            r_bearing_acc  <= '0;
            r_best_range   <= RANGE_MAX;
            r_best_bearing <= '0;
            r_left_min     <= RANGE_MAX;
            r_right_min    <= RANGE_MAX;
            r_front_min    <= RANGE_MAX;
            r_hit_flag     <= 1'b0;
        end else if (i_upd && active) begin
            r_scan_start   <= n_scan_start;
            r_bearing_acc  <= n_bearing_acc;
            r_best_range   <= n_best_range;
            r_best_bearing <= n_best_bearing;
            r_left_min     <= n_left_min;
            r_right_min    <= n_right_min;
            r_front_min    <= n_front_min;
            r_hit_flag     <= n_hit_flag;
        end
    end

endmodule

### rtl/scan_sector_minimum_unit.sv
// top level of the scan sector minimum block: input stage, accumulators, result register
// One range sample is taken per clock unless the input side stalls. A sample is held in
// an input register, the running bearing and the sector minima are updated from it in a
// single pass, and the sample flagged last_sample loads the result register and restarts
// the scan unless cone mode is off. Sustained rate is one sample per cycle without stalls;
// a result passes the input register and then the result register. The input side stalls
// only while a closing sample waits behind a result that the output side has not taken.
// Configuration writes are always ready and must only be made while no sample is in flight.
module scan_sector_minimum_unit
    import ssm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // sample request channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cfg      cfg;
    t_out_item res;
    logic      emit;
    logic      out_free;
    logic      advance;
    logic      in_accept;

    logic      r_s1_valid;
    t_in_item  r_s1_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    assign o_cfg_ready = 1'b1;

    ssm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    ssm_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_upd   (advance),
        .i_item  (r_s1_item),
        .o_res   (res),
        .o_emit  (emit)
    );

    // pipeline flow control
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_s1_valid && (out_free || !emit);
    assign o_in_stall = r_s1_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_item <= i_in_item;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out_item <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

### rtl/ssm_checker.sv
// port-level checks for the scan sector minimum block, bound to the top level
module ssm_checker
    import ssm_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // a held result stays on the port unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("result changed while stalled");

    // input backpressure only comes from a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    // a scan with no valid sample reports bearing zero
    a_empty_bearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.nearest_mm == RANGE_MAX))
            |-> (o_out_item.nearest_bearing == '0))
        else $error("empty scan with nonzero bearing");

    // the overall minimum never exceeds a sector minimum
    a_min_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_item.nearest_mm <= o_out_item.left_clear_mm)
            && (o_out_item.nearest_mm <= o_out_item.right_clear_mm)
            && (o_out_item.nearest_mm <= o_out_item.front_clear_mm)))
        else $error("nearest range above a sector minimum");

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind scan_sector_minimum_unit ssm_checker u_ssm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

### tb/tb_scan_sector_minimum_unit.sv
// self-checking testbench for the scan sector minimum block
module tb_scan_sector_minimum_unit
    import ssm_pkg::*;
;

    localparam int HALF_PERIOD   = 10;
    localparam int ITEM_TARGET   = 1350;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_SHOWN     = 10;
    localparam int RUN_LIMIT     = 4_000_000;

    // sector bounds worked out independently of the package
    localparam t_angle ARC_QUARTER = 16'h4000;
    localparam t_angle ARC_THREE_Q = 16'hC000;
    localparam t_angle ARC_30      = 16'd5461;
    localparam t_angle ARC_330     = 16'd60075;

    // directed configuration presets
    localparam int PRE_KEEP    = -1;
    localparam int PRE_QUARTER = 0;
    localparam int PRE_NARROW  = 1;
    localparam int PRE_EDGE    = 2;
    localparam int PRE_OFF     = 3;
    localparam int PRE_SWING   = 4;
    localparam int PRE_COUNT   = 5;

    typedef struct {
        int        preset;
        t_in_item  sample;
        bit        typed;
        t_out_item want;
    } t_row;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_in_item             i_in_item   = '0;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data  = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic                 o_cfg_ready;
    t_out_item            o_out_item;

    int send_idle_pct = 25;
    int recv_idle_pct = 76;
    int mismatches    = 0;

    // predictor copy of registers and scan accumulators
    t_cfg      cfg_shadow;
    t_angle    scan_bearing;
    logic      scan_fresh;
    t_range    near_range;
    t_angle    near_bearing;
    t_range    left_low;
    t_range    right_low;
    t_range    front_low;
    logic      hit_seen;
    t_out_item scan_results[$];

    t_cfg      presets[PRE_COUNT];
    t_row      plan[$];

    scan_sector_minimum_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // result checking and receiver back-pressure
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (scan_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN) begin
                    $display("unexpected result near %0d brg %0d", o_out_item.nearest_mm,
                             o_out_item.nearest_bearing);
                end
            end else begin
                want = scan_results.pop_front();
                if (o_out_item !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN) begin
                        $display("mismatch exp near %0d brg %0d left %0d right %0d front %0d obs %0b",
                                 want.nearest_mm, want.nearest_bearing, want.left_clear_mm,
                                 want.right_clear_mm, want.front_clear_mm, want.obstacle_seen);
                        $display("         got near %0d brg %0d left %0d right %0d front %0d obs %0b",
                                 o_out_item.nearest_mm, o_out_item.nearest_bearing,
                                 o_out_item.left_clear_mm, o_out_item.right_clear_mm,
                                 o_out_item.front_clear_mm, o_out_item.obstacle_seen);
                    end
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // accumulators back to an empty scan
    task automatic restart_scan();
        scan_fresh   = 1'b1;
        scan_bearing = '0;
        near_range   = 16'hFFFF;
        near_bearing = '0;
        left_low     = 16'hFFFF;
        right_low    = 16'hFFFF;
        front_low    = 16'hFFFF;
        hit_seen     = 1'b0;
    endtask

    // expected outcome of one accepted request
    task automatic predict_sample(input t_in_item s, input bit typed, input t_out_item want);
        t_angle    b;
        logic      in_front;
        logic      in_wide;
        t_out_item res;
        if (cfg_shadow.cone_mode == MODE_OFF) return;
        b            = scan_fresh ? cfg_shadow.start_angle : scan_bearing;
        scan_bearing = b + t_angle'(cfg_shadow.angle_step);
        scan_fresh   = 1'b0;
        if (s.sample_valid) begin
            in_front = (b <= ARC_30) || (b >= ARC_330);
            in_wide  = (b <= ARC_QUARTER) || (b >= ARC_THREE_Q);
            if (s.range_mm < near_range) begin
                near_range   = s.range_mm;
                near_bearing = b;
            end
            if (b != '0 && b <= ARC_QUARTER) begin
                if (s.range_mm < left_low) left_low = s.range_mm;
            end else if (b >= ARC_THREE_Q) begin
                if (s.range_mm < right_low) right_low = s.range_mm;
            end
            if (in_front && s.range_mm < front_low) front_low = s.range_mm;
            if (cfg_shadow.cone_mode == MODE_WIDE && in_wide
                && s.range_mm < cfg_shadow.wide_limit_mm) begin
                hit_seen = 1'b1;
            end else if (cfg_shadow.cone_mode == MODE_NARROW && in_front
                && s.range_mm < cfg_shadow.narrow_limit_mm) begin
                hit_seen = 1'b1;
            end
        end
        if (s.last_sample) begin
            res.nearest_mm      = near_range;
            res.nearest_bearing = near_bearing;
            res.left_clear_mm   = left_low;
            res.right_clear_mm  = right_low;
            res.front_clear_mm  = front_low;
            res.obstacle_seen   = hit_seen;
            if (typed) res = want;
            scan_results = {scan_results, res};
            restart_scan();
        end
    endtask

    // one request, after a random idle gap
    task automatic send_sample(input t_in_item s, input bit typed, input t_out_item want);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= s;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_sample(s, typed, want);
    endtask

    // let the block go idle before a register write
    task automatic settle();
        i_in_valid <= 1'b0;
        while (scan_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [CFG_DAT_W-1:0] cfg_value(input t_cfg c, input t_cfg_idx idx);
        case (idx)
            CFG_START_ANGLE:  cfg_value = c.start_angle;
            CFG_ANGLE_STEP:   cfg_value = c.angle_step;
            CFG_CONE_MODE:    cfg_value = CFG_DAT_W'(c.cone_mode);
            CFG_WIDE_LIMIT:   cfg_value = c.wide_limit_mm;
            CFG_NARROW_LIMIT: cfg_value = c.narrow_limit_mm;
            default:          cfg_value = '0;
        endcase
    endfunction

    // write every register, valid held high across the sequence
    task automatic load_config(input t_cfg c);
        t_cfg_idx             idx;
        logic [CFG_DAT_W-1:0] d;
        idx = idx.first();
        do begin
            d = cfg_value(c, idx);
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= d;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            case (idx)
                CFG_START_ANGLE:  cfg_shadow.start_angle     = d;
                CFG_ANGLE_STEP:   cfg_shadow.angle_step      = d;
                CFG_CONE_MODE:    cfg_shadow.cone_mode       = t_cone_mode'(d[1:0]);
                CFG_WIDE_LIMIT:   cfg_shadow.wide_limit_mm   = d;
                CFG_NARROW_LIMIT: cfg_shadow.narrow_limit_mm = d;
                default: ;
            endcase
            idx = idx.next();
        end while (idx != idx.first());
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_cfg mk_cfg(input t_angle start, input logic [15:0] step,
                                    input t_cone_mode mode, input t_range wide,
                                    input t_range narrow);
        mk_cfg.start_angle     = start;
        mk_cfg.angle_step      = step;
        mk_cfg.cone_mode       = mode;
        mk_cfg.wide_limit_mm   = wide;
        mk_cfg.narrow_limit_mm = narrow;
    endfunction

    function automatic t_out_item outcome(input t_range n, input t_angle b, input t_range l,
                                          input t_range r, input t_range f, input logic o);
        outcome.nearest_mm      = n;
        outcome.nearest_bearing = b;
        outcome.left_clear_mm   = l;
        outcome.right_clear_mm  = r;
        outcome.front_clear_mm  = f;
        outcome.obstacle_seen   = o;
    endfunction

    task automatic add_row(input int preset, input t_range r, input logic v, input logic l,
                           input bit typed, input t_out_item want);
        t_row row;
        row.preset             = preset;
        row.sample.range_mm    = r;
        row.sample.sample_valid = v;
        row.sample.last_sample = l;
        row.typed              = typed;
        row.want               = want;
        plan = {plan, row};
    endtask

    // word with a bias towards the extremes
    function automatic logic [15:0] pick_word();
        case ($urandom_range(7))
            0:       pick_word = 16'h0000;
            1:       pick_word = 16'hFFFF;
            2:       pick_word = 16'h8000;
            3:       pick_word = 16'h7FFF;
            default: pick_word = 16'($urandom);
        endcase
    endfunction

    // indoor-scale ranges and full-width values in equal share, plus some extremes
    function automatic t_range pick_range();
        case ($urandom_range(9))
            0:          pick_range = 16'h0000;
            1:          pick_range = 16'hFFFF;
            2, 3, 4, 5: pick_range = 16'($urandom_range(3000));
            default:    pick_range = 16'($urandom);
        endcase
    endfunction

    function automatic t_cfg random_config();
        t_cone_mode mode;
        mode = ($urandom_range(9) == 0) ? MODE_OFF : t_cone_mode'(2'($urandom_range(2)));
        random_config = mk_cfg(pick_word(),
                               $urandom_range(1) ? pick_word() : 16'($urandom_range(1, 700)),
                               mode,
                               $urandom_range(1) ? pick_word() : 16'($urandom_range(3000)),
                               $urandom_range(1) ? pick_word() : 16'($urandom_range(3000)));
    endfunction

    // stimulus
    initial begin
        t_in_item s;
        t_cfg     seg_cfg;
        int       counted;
        int       scan_left;
        int       seg_len;

        cfg_shadow = mk_cfg(16'd0, 16'd0, MODE_WIDE, 16'd1200, 16'd200);
        restart_scan();

        presets[PRE_QUARTER] = mk_cfg(16'd0, 16'h4000, MODE_WIDE, 16'd750, 16'd200);
        presets[PRE_NARROW]  = mk_cfg(ARC_330, ARC_30, MODE_NARROW, 16'd1200, 16'd150);
        presets[PRE_EDGE]    = mk_cfg(16'd5462, 16'd10922, MODE_NONE, 16'hFFFF, 16'hFFFF);
        presets[PRE_OFF]     = mk_cfg(16'd16385, 16'h8000, MODE_OFF, 16'd1200, 16'd200);
        presets[PRE_SWING]   = mk_cfg(16'hFFFF, 16'h8000, MODE_WIDE, 16'd0, 16'hFFFF);

        // reset values: empty scan, range extremes, threshold edge, invalid last sample
        add_row(PRE_KEEP, 16'd300, 1'b0, 1'b1, 1'b1,
                outcome(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
        add_row(PRE_KEEP, 16'd0, 1'b1, 1'b1, 1'b1,
                outcome(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 1'b1));
        add_row(PRE_KEEP, 16'hFFFF, 1'b1, 1'b1, 1'b1,
                outcome(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
        add_row(PRE_KEEP, 16'd1199, 1'b1, 1'b1, 1'b1,
                outcome(16'd1199, 16'd0, 16'hFFFF, 16'hFFFF, 16'd1199, 1'b1));
        add_row(PRE_KEEP, 16'd1200, 1'b1, 1'b1, 1'b1,
                outcome(16'd1200, 16'd0, 16'hFFFF, 16'hFFFF, 16'd1200, 1'b0));
        add_row(PRE_KEEP, 16'd500, 1'b1, 1'b0, 1'b0, '0);
        add_row(PRE_KEEP, 16'd300, 1'b0, 1'b1, 1'b1,
                outcome(16'd500, 16'd0, 16'hFFFF, 16'hFFFF, 16'd500, 1'b1));
        // quarter-turn steps through every sector, then a tie on the minimum
        add_row(PRE_QUARTER, 16'd1000, 1'b1, 1'b0, 1'b0, '0);
        add_row(PRE_KEEP, 16'd800, 1'b1, 1'b0, 1'b0, '0);
        add_row(PRE_KEEP, 16'd100, 1'b1, 1'b0, 1'b0, '0);
        add_row(PRE_KEEP, 16'd700, 1'b1, 1'b1, 1'b0, '0);
        add_row(PRE_KEEP, 16'd400, 1'b1, 1'b0, 1'b0, '0);
        add_row(PRE_KEEP, 16'd400, 1'b1, 1'b0, 1'b0, '0);
        add_row(PRE_KEEP, 16'd900, 1'b0, 1'b0, 1'b0, '0);
        add_row(PRE_KEEP, 16'd400, 1'b1, 1'b1, 1'b0, '0);
        // narrow cone on the 330 and 30 degree edges, wrapping through zero
        add_row(PRE_NARROW, 16'd150, 1'b1, 1'b0, 1'b0, '0);
        add_row(PRE_KEEP, 16'd149, 1'b1, 1'b0, 1'b0, '0);
        add_row(PRE_KEEP, 16'd120, 1'b1, 1'b0, 1'b0, '0);
        add_row(PRE_KEEP, 16'd90, 1'b1, 1'b1, 1'b0, '0);
        // just outside the front, on the quarter edge, no obstacle check
        add_row(PRE_EDGE, 16'd50, 1'b1, 1'b0, 1'b0, '0);
        add_row(PRE_KEEP, 16'd60, 1'b1, 1'b1, 1'b0, '0);
        // disabled mode swallows a closing sample
        add_row(PRE_OFF, 16'd10, 1'b1, 1'b1, 1'b0, '0);
        // extreme step and start, zero wide limit
        add_row(PRE_SWING, 16'd20, 1'b1, 1'b0, 1'b0, '0);
        add_row(PRE_KEEP, 16'd30, 1'b1, 1'b1, 1'b0, '0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (plan[k]) begin
            if (plan[k].preset != PRE_KEEP) begin
                settle();
                load_config(presets[plan[k].preset]);
            end
            send_sample(plan[k].sample, plan[k].typed, plan[k].want);
        end
        settle();

        // random scans, segments cut at random points so modes change mid-scan
        counted   = 0;
        scan_left = 0;
        while (counted < ITEM_TARGET) begin
            if (counted < ITEM_TARGET / 3) begin
                send_idle_pct = 25;
                recv_idle_pct = 76;
            end else if (counted < 2 * ITEM_TARGET / 3) begin
                send_idle_pct = 76;
                recv_idle_pct = 25;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            seg_cfg = random_config();
            load_config(seg_cfg);
            seg_len = (seg_cfg.cone_mode == MODE_OFF) ? 12 : $urandom_range(60, 160);
            repeat (seg_len) begin
                if (scan_left == 0) begin
                    scan_left = ($urandom_range(7) == 0) ? 1 : $urandom_range(2, 40);
                end
                s.range_mm     = pick_range();
                s.sample_valid = ($urandom_range(5) != 0);
                s.last_sample  = (scan_left == 1);
                // occasional broken scan framing
                if ($urandom_range(24) == 0) s.last_sample = ~s.last_sample;
                if (s.last_sample) scan_left = 0;
                else if (scan_left > 0) scan_left--;
                send_sample(s, 1'b0, '0);
                if (seg_cfg.cone_mode != MODE_OFF) counted++;
            end
            settle();
        end

        if (mismatches == 0) begin
            $display("PASS scan_sector_minimum_unit");
        end else begin
            $display("FAIL scan_sector_minimum_unit");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(RUN_LIMIT);
        $display("FAIL scan_sector_minimum_unit");
        $finish;
    end

endmodule
